[hdl/swlf_pkg.sv]
`timescale 1ns / 1ps

package swlf_pkg;

   // field widths of one beat
   localparam int TIME_STEP_W = 16;
   localparam int SAMPLE_W    = 32;
   localparam int TIME_W      = 24;
   localparam int RESULT_W    = 32;
   localparam int MEAN_W      = 31;

   // newest time saturates here
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LEN_RAW_W  = 7;
   localparam logic [LEN_RAW_W-1:0] LEN_RESET = 7'd16;
   localparam int LEN_MIN = 2;

   // register index, taken from address bit 2
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   // multiplier digit width and the index of the last product per fit
   localparam int DIGIT_W = 8;
   localparam logic [2:0] LAST_PRODUCT = 3'd5;

   typedef struct packed {
      logic        [TIME_STEP_W-1:0] time_step;
      logic signed [SAMPLE_W-1:0]    sample_value;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] slope;
      logic signed [RESULT_W-1:0] intercept;
      logic signed [RESULT_W-1:0] smoothed_value;
      logic        [MEAN_W-1:0]   mean_abs_residual;
      logic                       fit_degenerate;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_SHIFT,
      ST_NEWEST,
      ST_MLD,
      ST_MUL,
      ST_MCB,
      ST_CHK,
      ST_DLD,
      ST_DIV,
      ST_DEND,
      ST_RLD,
      ST_RES,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_SLOPE,
      DIV_ICPT,
      DIV_MEAN
   } div_sel_type;

endpackage

[hdl/swlf_queue.sv]
`timescale 1ns / 1ps

// two-entry queue; parts the engine from each neighbour
module swlf_queue #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = entry_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wp_in    = do_push ? ~wp_ff : wp_ff;
      rp_in    = do_pop ? ~rp_ff : rp_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wp_ff] <= wdata;
   end

endmodule

[hdl/swlf_engine.sv]
`timescale 1ns / 1ps

// window walk, sums, products, shared divider and residual walk
module swlf_engine #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]    len,
   input  swlf_pkg::req_type                  item,
   input  logic                               item_valid,
   output logic                               item_take,
   output swlf_pkg::rsp_type                  result,
   output logic                               result_push,
   input  logic                               result_full
);

   localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LW     = $clog2(MAX_WINDOW + 1);
   localparam int TW     = swlf_pkg::TIME_W;
   localparam int YW     = swlf_pkg::SAMPLE_W;
   localparam int ENT_W  = TW + YW;
   localparam int SXX_W  = 2 * TW + LW;
   localparam int SX_W   = TW + LW;
   localparam int SXY_W  = TW + YW + LW;
   localparam int SY_W   = YW + LW;
   localparam int MA_W   = SXY_W;
   localparam int ND     = (MA_W + swlf_pkg::DIGIT_W - 1) / swlf_pkg::DIGIT_W;
   localparam int MB_W   = ND * swlf_pkg::DIGIT_W;
   localparam int PW     = MA_W + MB_W;
   localparam int NUM_W  = 3 * TW + YW + 1 + 2 * LW;
   localparam int DEN_W  = 2 * TW + 2 * LW;
   localparam int SUM_W  = TW + YW + 2 + LW;
   localparam int DGW    = $clog2(ND);
   localparam int CNW    = $clog2(NUM_W);
   localparam int FIT_W  = TW + YW + 2;

   swlf_pkg::state_type   state_ff, state_in;
   swlf_pkg::div_sel_type dsel_ff, dsel_in;

   // window memory with per-entry valid bits
   logic [ENT_W-1:0]      mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] vld_ff;
   logic [ENT_W-1:0]      rdat_ff;
   logic                  rvld_ff;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [ENT_W-1:0]      wr_data;

   logic [swlf_pkg::TIME_STEP_W-1:0] dt_ff, dt_in;
   logic signed [YW-1:0]  y_ff, y_in;
   logic [LW-1:0]         fill_ff, fill_in, fill_clip;
   logic [LW-1:0]         iss_ff, iss_in, ridx_ff, ridx_in;
   logic                  rv_ff, rv_in;
   logic [TW-1:0]         base_ff, base_in, last_ff, last_in;
   logic [SXX_W-1:0]      sxx_ff, sxx_in;
   logic [SX_W-1:0]       sx_ff, sx_in;
   logic signed [SXY_W-1:0] sxy_ff, sxy_in;
   logic signed [SY_W-1:0]  sy_ff, sy_in;
   logic [2:0]            step_ff, step_in;
   logic [DGW-1:0]        dig_ff, dig_in;
   logic [MA_W-1:0]       ma_ff, ma_in;
   logic [MB_W-1:0]       mb_ff, mb_in;
   logic                  mneg_ff, mneg_in;
   logic [PW-1:0]         macc_ff, macc_in;
   logic signed [NUM_W-1:0] ptmp_ff, ptmp_in, numk_ff, numk_in, numb_ff, numb_in;
   logic [DEN_W-1:0]      den_ff, den_in, dden_ff, dden_in, drem_ff, drem_in;
   logic [NUM_W-1:0]      dnum_ff, dnum_in;
   logic                  dneg_ff, dneg_in;
   logic [CNW-1:0]        dcnt_ff, dcnt_in;
   logic signed [YW-1:0]  k_ff, k_in, b_ff, b_in, hk_ff, hk_in, hb_ff, hb_in;
   logic signed [YW-1:0]  smooth_ff, smooth_in;
   logic [swlf_pkg::MEAN_W-1:0] mean_ff, mean_in;
   logic                  degen_ff, degen_in;
   logic [SUM_W-1:0]      asum_ff, asum_in;

   // shared combinational terms
   logic [TW-1:0]         ent_t, tn, tnew;
   logic signed [YW-1:0]  ent_y;
   logic [TW:0]           tsum;
   logic [LW-1:0]         len_m1;
   logic                  hit, last_ret;
   logic                  acc_en;
   logic [TW-1:0]         acc_t;
   logic signed [YW-1:0]  acc_y;
   logic [LW:0]           nsum;
   logic [MA_W+swlf_pkg::DIGIT_W-1:0] pp;
   logic signed [NUM_W-1:0] prod, diff;
   logic [DEN_W:0]        rsh;
   logic                  ge;
   logic                  q_big;
   logic signed [YW-1:0]  q_sat;
   logic signed [FIT_W-1:0] fit;
   logic signed [FIT_W:0]   err;
   logic [FIT_W:0]        err_mag;
   logic                  fit_ok;
   logic [SXY_W-1:0]      sxy_mag;
   logic [SY_W-1:0]       sy_mag;

   // memory, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rdat_ff <= mem[rd_addr];
         rvld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (wr_en) vld_ff[wr_addr] <= 1'b1;
   end

   // an entry never written reads as zero
   always_comb begin
      ent_t    = rvld_ff ? rdat_ff[ENT_W-1:YW] : '0;
      ent_y    = rvld_ff ? $signed(rdat_ff[YW-1:0]) : '0;
      len_m1   = len - LW'(1);
      last_ret = rv_ff && (ridx_ff == len_m1);
      // rebase against the time of window position 1
      if (ridx_ff == LW'(1)) tn = '0;
      else if (ent_t >= base_ff) tn = ent_t - base_ff;
      else tn = '0;
      tsum     = {1'b0, last_ff} + (TW+1)'(dt_ff);
      tnew     = tsum[TW] ? swlf_pkg::TIME_MAX : tsum[TW-1:0];
      nsum     = {1'b0, ridx_ff} + {1'b0, fill_ff};
      hit      = nsum > {1'b0, len};
      fill_clip = (fill_ff > len) ? len : fill_ff;
      sxy_mag  = sxy_ff[SXY_W-1] ? SXY_W'(-sxy_ff) : SXY_W'(sxy_ff);
      sy_mag   = sy_ff[SY_W-1] ? SY_W'(-sy_ff) : SY_W'(sy_ff);
   end

   // sum inputs: shifted entries in the fitted range, then the newest entry
   always_comb begin
      acc_en = 1'b0;
      acc_t  = tn;
      acc_y  = ent_y;
      if (state_ff == swlf_pkg::ST_SHIFT) begin
         acc_en = rv_ff && hit;
      end else if (state_ff == swlf_pkg::ST_NEWEST) begin
         acc_en = 1'b1;
         acc_t  = tnew;
         acc_y  = y_ff;
      end
   end

   // multiplier, divider and residual terms
   always_comb begin
      pp     = ma_ff * mb_ff[MB_W-1 -: swlf_pkg::DIGIT_W];
      prod   = $signed(macc_ff[NUM_W-1:0]);
      if (mneg_ff) prod = -prod;
      diff   = ptmp_ff - prod;
      rsh    = {drem_ff, dnum_ff[NUM_W-1]};
      ge     = rsh >= {1'b0, dden_ff};
      q_big  = |dnum_ff[NUM_W-1:YW-1];
      if (q_big) q_sat = dneg_ff ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}};
      else q_sat = dneg_ff ? -$signed(dnum_ff[YW-1:0]) : $signed(dnum_ff[YW-1:0]);
      fit    = FIT_W'($signed(k_ff) * $signed({1'b0, ent_t})) + FIT_W'(b_ff);
      err    = (FIT_W+1)'(fit) - (FIT_W+1)'(ent_y);
      err_mag = err[FIT_W] ? (FIT_W+1)'(-err) : (FIT_W+1)'(err);
      fit_ok = (&fit[FIT_W-1:YW-1]) || !(|fit[FIT_W-1:YW-1]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swlf_pkg::ST_IDLE:   if (item_valid) state_in = swlf_pkg::ST_FILL;
         swlf_pkg::ST_FILL:   state_in = swlf_pkg::ST_SHIFT;
         swlf_pkg::ST_SHIFT:  if (last_ret) state_in = swlf_pkg::ST_NEWEST;
         swlf_pkg::ST_NEWEST: state_in = swlf_pkg::ST_MLD;
         swlf_pkg::ST_MLD:    state_in = swlf_pkg::ST_MUL;
         swlf_pkg::ST_MUL:    if (dig_ff == DGW'(ND - 1)) state_in = swlf_pkg::ST_MCB;
         swlf_pkg::ST_MCB:    state_in = (step_ff == swlf_pkg::LAST_PRODUCT) ?
                                         swlf_pkg::ST_CHK : swlf_pkg::ST_MLD;
         swlf_pkg::ST_CHK:    state_in = (den_ff == '0) ? swlf_pkg::ST_RLD : swlf_pkg::ST_DLD;
         swlf_pkg::ST_DLD:    state_in = swlf_pkg::ST_DIV;
         swlf_pkg::ST_DIV:    if (dcnt_ff == CNW'(NUM_W - 1)) state_in = swlf_pkg::ST_DEND;
         swlf_pkg::ST_DEND: begin
            unique case (dsel_ff)
               swlf_pkg::DIV_SLOPE: state_in = swlf_pkg::ST_DLD;
               swlf_pkg::DIV_ICPT:  state_in = swlf_pkg::ST_RLD;
               default:             state_in = swlf_pkg::ST_OUT;
            endcase
         end
         swlf_pkg::ST_RLD:    state_in = swlf_pkg::ST_RES;
         swlf_pkg::ST_RES:    if (last_ret) state_in = swlf_pkg::ST_DLD;
         swlf_pkg::ST_OUT:    if (!result_full) state_in = swlf_pkg::ST_IDLE;
         default:             state_in = swlf_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshakes and memory ports
   always_comb begin
      item_take   = 1'b0;
      result_push = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = iss_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = AW'(ridx_ff - LW'(1));
      wr_data     = {tn, ent_y};
      unique case (state_ff)
         swlf_pkg::ST_IDLE: item_take = item_valid;
         swlf_pkg::ST_SHIFT: begin
            rd_en = iss_ff < len;
            wr_en = rv_ff;
         end
         swlf_pkg::ST_NEWEST: begin
            wr_en   = 1'b1;
            wr_addr = len_m1[AW-1:0];
            wr_data = {tnew, y_ff};
         end
         swlf_pkg::ST_RES: rd_en = iss_ff < len;
         swlf_pkg::ST_OUT: result_push = !result_full;
         default: ;
      endcase
   end

   assign result = '{slope: k_ff, intercept: b_ff, smoothed_value: smooth_ff,
                     mean_abs_residual: mean_ff, fit_degenerate: degen_ff};

   // datapath next values
   always_comb begin
      dt_in = dt_ff;   y_in = y_ff;   fill_in = fill_ff;
      iss_in = rd_en ? iss_ff + LW'(1) : iss_ff;
      rv_in = rd_en;   ridx_in = iss_ff;
      base_in = base_ff;   last_in = last_ff;
      sxx_in = sxx_ff;   sx_in = sx_ff;   sxy_in = sxy_ff;   sy_in = sy_ff;
      step_in = step_ff;   dig_in = dig_ff;
      ma_in = ma_ff;   mb_in = mb_ff;   mneg_in = mneg_ff;   macc_in = macc_ff;
      ptmp_in = ptmp_ff;   numk_in = numk_ff;   numb_in = numb_ff;   den_in = den_ff;
      dden_in = dden_ff;   drem_in = drem_ff;   dnum_in = dnum_ff;
      dneg_in = dneg_ff;   dcnt_in = dcnt_ff;   dsel_in = dsel_ff;
      k_in = k_ff;   b_in = b_ff;   hk_in = hk_ff;   hb_in = hb_ff;
      smooth_in = smooth_ff;   mean_in = mean_ff;   degen_in = degen_ff;
      asum_in = asum_ff;

      // running sums over the fitted entries
      if (acc_en) begin
         sxx_in = sxx_ff + SXX_W'(acc_t * acc_t);
         sx_in  = sx_ff + SX_W'(acc_t);
         sxy_in = sxy_ff + SXY_W'($signed({1'b0, acc_t}) * acc_y);
         sy_in  = sy_ff + SY_W'(acc_y);
      end

      unique case (state_ff)
         swlf_pkg::ST_IDLE: begin
            if (item_valid) begin
               dt_in = item.time_step;
               y_in  = item.sample_value;
            end
         end
         swlf_pkg::ST_FILL: begin
            fill_in = (fill_clip < len) ? fill_clip + LW'(1) : fill_clip;
            iss_in  = LW'(1);
            sxx_in  = '0;   sx_in = '0;   sxy_in = '0;   sy_in = '0;
         end
         swlf_pkg::ST_SHIFT: begin
            if (rv_ff) begin
               if (ridx_ff == LW'(1)) base_in = ent_t;
               last_in = tn;
            end
         end
         swlf_pkg::ST_NEWEST: step_in = '0;
         // operand pairs: n*Sxx, Sx*Sx, n*Sxy, Sx*Sy, Sxx*Sy, Sx*Sxy
         swlf_pkg::ST_MLD: begin
            macc_in = '0;
            dig_in  = '0;
            unique case (step_ff)
               3'd0: begin ma_in = MA_W'(fill_ff); mb_in = MB_W'(sxx_ff); mneg_in = 1'b0; end
               3'd1: begin ma_in = MA_W'(sx_ff);   mb_in = MB_W'(sx_ff);  mneg_in = 1'b0; end
               3'd2: begin
                  ma_in = MA_W'(fill_ff); mb_in = MB_W'(sxy_mag); mneg_in = sxy_ff[SXY_W-1];
               end
               3'd3: begin
                  ma_in = MA_W'(sx_ff); mb_in = MB_W'(sy_mag); mneg_in = sy_ff[SY_W-1];
               end
               3'd4: begin
                  ma_in = MA_W'(sxx_ff); mb_in = MB_W'(sy_mag); mneg_in = sy_ff[SY_W-1];
               end
               default: begin
                  ma_in = MA_W'(sx_ff); mb_in = MB_W'(sxy_mag); mneg_in = sxy_ff[SXY_W-1];
               end
            endcase
         end
         // one digit of the multiplier a cycle, most significant first
         swlf_pkg::ST_MUL: begin
            macc_in = (macc_ff << swlf_pkg::DIGIT_W) + PW'(pp);
            mb_in   = mb_ff << swlf_pkg::DIGIT_W;
            dig_in  = dig_ff + DGW'(1);
         end
         swlf_pkg::ST_MCB: begin
            step_in = step_ff + 3'd1;
            if (!step_ff[0]) ptmp_in = prod;
            else begin
               unique case (step_ff)
                  3'd1:    den_in  = diff[DEN_W-1:0];
                  3'd3:    numk_in = diff;
                  default: numb_in = diff;
               endcase
            end
         end
         swlf_pkg::ST_CHK: begin
            if (den_ff == '0) begin
               degen_in = 1'b1;
               k_in     = hk_ff;
               b_in     = hb_ff;
            end else begin
               degen_in = 1'b0;
               dsel_in  = swlf_pkg::DIV_SLOPE;
            end
         end
         swlf_pkg::ST_DLD: begin
            drem_in = '0;
            dcnt_in = '0;
            unique case (dsel_ff)
               swlf_pkg::DIV_SLOPE: begin
                  dneg_in = numk_ff[NUM_W-1];
                  dnum_in = numk_ff[NUM_W-1] ? NUM_W'(-numk_ff) : NUM_W'(numk_ff);
                  dden_in = den_ff;
               end
               swlf_pkg::DIV_ICPT: begin
                  dneg_in = numb_ff[NUM_W-1];
                  dnum_in = numb_ff[NUM_W-1] ? NUM_W'(-numb_ff) : NUM_W'(numb_ff);
                  dden_in = den_ff;
               end
               default: begin
                  dneg_in = 1'b0;
                  dnum_in = NUM_W'(asum_ff);
                  dden_in = DEN_W'(fill_ff);
               end
            endcase
         end
         // restoring division, one quotient bit a cycle
         swlf_pkg::ST_DIV: begin
            drem_in = ge ? DEN_W'(rsh - {1'b0, dden_ff}) : rsh[DEN_W-1:0];
            dnum_in = {dnum_ff[NUM_W-2:0], ge};
            dcnt_in = dcnt_ff + CNW'(1);
         end
         swlf_pkg::ST_DEND: begin
            unique case (dsel_ff)
               swlf_pkg::DIV_SLOPE: begin
                  k_in    = q_sat;
                  dsel_in = swlf_pkg::DIV_ICPT;
               end
               swlf_pkg::DIV_ICPT: begin
                  b_in  = q_sat;
                  hk_in = k_ff;
                  hb_in = q_sat;
               end
               default: mean_in = q_big ? {swlf_pkg::MEAN_W{1'b1}} :
                                          dnum_ff[swlf_pkg::MEAN_W-1:0];
            endcase
         end
         swlf_pkg::ST_RLD: begin
            iss_in  = len - fill_ff;
            asum_in = '0;
         end
         // residual walk; the newest entry also gives the smoothed value
         swlf_pkg::ST_RES: begin
            if (rv_ff) begin
               asum_in = asum_ff + SUM_W'(err_mag);
               if (last_ret) begin
                  dsel_in = swlf_pkg::DIV_MEAN;
                  if (fit_ok) smooth_in = fit[YW-1:0];
                  else smooth_in = fit[FIT_W-1] ? {1'b1, {(YW-1){1'b0}}} :
                                                  {1'b0, {(YW-1){1'b1}}};
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swlf_pkg::ST_IDLE;
         dsel_ff  <= swlf_pkg::DIV_SLOPE;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
         iss_ff   <= '0;
         hk_ff    <= '0;
         hb_ff    <= '0;
         step_ff  <= '0;
         dig_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
         iss_ff   <= iss_in;
         hk_ff    <= hk_in;
         hb_ff    <= hb_in;
         step_ff  <= step_in;
         dig_ff   <= dig_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dt_ff <= dt_in;   y_ff <= y_in;   ridx_ff <= ridx_in;
      base_ff <= base_in;   last_ff <= last_in;
      sxx_ff <= sxx_in;   sx_ff <= sx_in;   sxy_ff <= sxy_in;   sy_ff <= sy_in;
      ma_ff <= ma_in;   mb_ff <= mb_in;   mneg_ff <= mneg_in;   macc_ff <= macc_in;
      ptmp_ff <= ptmp_in;   numk_ff <= numk_in;   numb_ff <= numb_in;   den_ff <= den_in;
      dden_ff <= dden_in;   drem_ff <= drem_in;   dnum_ff <= dnum_in;   dneg_ff <= dneg_in;
      k_ff <= k_in;   b_ff <= b_in;   smooth_ff <= smooth_in;   mean_ff <= mean_in;
      degen_ff <= degen_in;   asum_ff <= asum_in;
   end

endmodule

[hdl/sliding_window_line_fit_unit.sv]
`timescale 1ns / 1ps

// Sliding-window least-squares line fit, Q16.16.
// Input beats (req_push / req_full) carry a time step and a sample; each gives one
// result beat (rsp_empty / rsp_pop) with slope, intercept, smoothed value, mean
// absolute residual and a degenerate-fit flag. window_length is set over the
// APB-style csr_ port; the user must write it only while the block is idle, which
// the block itself does not enforce. Values outside [2, MAX_WINDOW] clamp. A
// two-entry queue sits on each side of the fit engine, so two beats can be taken
// while a result waits, and a stalled receiver only holds the engine in its final
// state until a result slot frees. At MAX_WINDOW 64 the multiplier has ND = 8
// digits and the divider a numerator of NUM_W = 119 bits. The one-bit-a-cycle
// divider, run for slope, intercept and mean, takes most of the time of a fit;
// a degenerate fit skips two divisions. Items are taken one at a time.
// Reset (synchronous): window entries read as zero, fill count and held fit clear,
// window_length returns to 16. No clearing pass is needed.
module sliding_window_line_fit_unit #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  swlf_pkg::req_type                   req_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output swlf_pkg::rsp_type                   rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swlf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swlf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swlf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int CW = (LW > swlf_pkg::LEN_RAW_W) ? LW : swlf_pkg::LEN_RAW_W;

   logic [swlf_pkg::LEN_RAW_W-1:0] len_raw_ff, len_raw_in;
   logic [LW-1:0]                  len;
   logic                           reg_sel;
   swlf_pkg::req_type              q_item;
   swlf_pkg::rsp_type              e_result;
   logic                           q_empty, take, push, rfull;

   // register file
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == swlf_pkg::REG_WINDOW_LENGTH);

   always_comb begin
      len_raw_in = len_raw_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel)
         len_raw_in = csr_pwdata[swlf_pkg::LEN_RAW_W-1:0];
      csr_prdata = reg_sel ? swlf_pkg::CSR_DATA_W'(len_raw_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) len_raw_ff <= swlf_pkg::LEN_RESET;
      else len_raw_ff <= len_raw_in;
   end

   // effective length
   always_comb begin
      if (CW'(len_raw_ff) < CW'(swlf_pkg::LEN_MIN)) len = LW'(swlf_pkg::LEN_MIN);
      else if (CW'(len_raw_ff) > CW'(MAX_WINDOW)) len = LW'(MAX_WINDOW);
      else len = LW'(len_raw_ff);
   end

   // front: input beats
   swlf_queue #(.WIDTH($bits(swlf_pkg::req_type))) u_req_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (req_item),
      .pop   (take),
      .empty (q_empty),
      .rdata (q_item)
   );

   // back: the fit
   swlf_engine #(.MAX_WINDOW(MAX_WINDOW)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .len         (len),
      .item        (q_item),
      .item_valid  (!q_empty),
      .item_take   (take),
      .result      (e_result),
      .result_push (push),
      .result_full (rfull)
   );

   // result beats
   swlf_queue #(.WIDTH($bits(swlf_pkg::rsp_type))) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (rfull),
      .wdata (e_result),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_item)
   );

endmodule
